FILE: sv/modexp_pkg.sv
// Shared types and constants for the modular exponentiation block.
package modexp_pkg;
  localparam int unsigned OperandWidth = 128;
  localparam int unsigned HalfWidth = 64;

  typedef enum logic [1:0] {
    RegModLo = 2'd0,
    RegModHi = 2'd1,
    RegExpLo = 2'd2,
    RegExpHi = 2'd3
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StMulAcc,
    StSquare,
    StDone
  } state_e;

  typedef enum logic [1:0] {
    OpReduce,
    OpMulAcc,
    OpSquare
  } mul_op_e;

  typedef struct packed {
    logic    load;
    logic    start;
    mul_op_e op;
    logic    set_one;
    logic    exp_shift;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic mod_zero;
    logic mod_one;
    logic base_zero;
    logic exp_bit;
    logic last_bit;
  } dp_status_t;
endpackage

FILE: sv/modexp_datapath.sv
// Datapath: operand registers and a bit-serial interleaved modular multiplier.
module modexp_datapath #(
  parameter int unsigned OperandWidth = modexp_pkg::OperandWidth
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  modexp_pkg::dp_cmd_t     cmd_i,
  input  logic [OperandWidth-1:0] modulus_i,
  input  logic [OperandWidth-1:0] exponent_i,
  input  logic [OperandWidth-1:0] base_i,
  output modexp_pkg::dp_status_t  status_o,
  output logic [OperandWidth-1:0] acc_o
);
  localparam int unsigned CntW = $clog2(OperandWidth);

  logic [OperandWidth-1:0] mod_q, exp_q, base_q, acc_q, mpl_q, mcd_q, r_q;
  logic [OperandWidth-1:0] mod_d, exp_d, base_d, acc_d, mpl_d, mcd_d, r_d;
  logic [CntW-1:0] cnt_q, cnt_d, ecnt_q, ecnt_d;
  logic busy_q, busy_d, done_q, done_d;
  modexp_pkg::mul_op_e op_q, op_d;
  logic [OperandWidth:0] dbl, dbl_red, sum, sum_red;
  logic [OperandWidth-1:0] r_dbl;

  always_comb begin
    dbl = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, mod_q}) ? dbl - {1'b0, mod_q} : dbl;
    r_dbl = dbl_red[OperandWidth-1:0];
    sum = {1'b0, r_dbl} + {1'b0, mcd_q};
    sum_red = (sum >= {1'b0, mod_q}) ? sum - {1'b0, mod_q} : sum;
  end

  always_comb begin
    mod_d = mod_q; exp_d = exp_q; base_d = base_q; acc_d = acc_q;
    mpl_d = mpl_q; mcd_d = mcd_q; r_d = r_q; cnt_d = cnt_q; ecnt_d = ecnt_q;
    busy_d = busy_q; done_d = 1'b0; op_d = op_q;
    if (cmd_i.load) begin
      mod_d = modulus_i;
      exp_d = exponent_i;
      base_d = base_i;
      acc_d = '0;
      ecnt_d = '0;
    end
    if (cmd_i.set_one) begin
      acc_d = {{(OperandWidth-1){1'b0}}, 1'b1};
    end
    if (cmd_i.exp_shift) begin
      exp_d = exp_q >> 1;
      ecnt_d = ecnt_q + 1'b1;
    end
    if (cmd_i.start) begin
      busy_d = 1'b1;
      op_d = cmd_i.op;
      r_d = '0;
      cnt_d = '0;
      unique case (cmd_i.op)
        modexp_pkg::OpReduce: begin
          mpl_d = base_q;
          mcd_d = {{(OperandWidth-1){1'b0}}, 1'b1};
        end
        modexp_pkg::OpMulAcc: begin
          mpl_d = acc_q;
          mcd_d = base_q;
        end
        default: begin
          mpl_d = base_q;
          mcd_d = base_q;
        end
      endcase
    end else if (busy_q) begin
      r_d = mpl_q[OperandWidth-1] ? sum_red[OperandWidth-1:0] : r_dbl;
      mpl_d = mpl_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(OperandWidth-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (op_q == modexp_pkg::OpMulAcc) acc_d = r_d;
        else base_d = r_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q <= mod_d; exp_q <= exp_d; base_q <= base_d; acc_q <= acc_d;
    mpl_q <= mpl_d; mcd_q <= mcd_d; r_q <= r_d; cnt_q <= cnt_d;
    ecnt_q <= ecnt_d; op_q <= op_d;
  end

  always_comb begin
    status_o.busy = busy_q;
    status_o.done = done_q;
    status_o.mod_zero = (mod_q == '0);
    status_o.mod_one = (mod_q == {{(OperandWidth-1){1'b0}}, 1'b1});
    status_o.base_zero = (base_q == '0);
    status_o.exp_bit = exp_q[0];
    status_o.last_bit = (ecnt_q == CntW'(OperandWidth-1));
  end

  assign acc_o = acc_q;
endmodule

FILE: sv/modexp_ctrl.sv
// Controller state machine sequencing reduction and square-and-multiply.
module modexp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   err_o,
  output logic                   clr_o,
  output modexp_pkg::dp_cmd_t    cmd_o,
  input  modexp_pkg::dp_status_t status_i
);
  modexp_pkg::state_e state_q, state_d;
  logic started_q, started_d, err_q, err_d, clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= modexp_pkg::StIdle;
      started_q <= 1'b0;
      err_q <= 1'b0;
      clr_q <= 1'b0;
    end else begin
      state_q <= state_d;
      started_q <= started_d;
      err_q <= err_d;
      clr_q <= clr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    started_d = started_q;
    err_d = err_q;
    clr_d = clr_q;
    cmd_o = '0;
    cmd_o.op = modexp_pkg::OpReduce;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      modexp_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          started_d = 1'b0;
          state_d = modexp_pkg::StReduce;
        end
      end
      modexp_pkg::StReduce: begin
        if (!started_q) begin
          if (status_i.mod_zero || status_i.mod_one) begin
            err_d = status_i.mod_zero;
            clr_d = 1'b1;
            state_d = modexp_pkg::StDone;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.op = modexp_pkg::OpReduce;
            started_d = 1'b1;
          end
        end else if (status_i.done) begin
          started_d = 1'b0;
          err_d = 1'b0;
          clr_d = 1'b0;
          if (status_i.base_zero) begin
            state_d = modexp_pkg::StDone;
          end else begin
            cmd_o.set_one = 1'b1;
            state_d = modexp_pkg::StMulAcc;
          end
        end
      end
      modexp_pkg::StMulAcc: begin
        if (!started_q) begin
          if (status_i.exp_bit) begin
            cmd_o.start = 1'b1;
            cmd_o.op = modexp_pkg::OpMulAcc;
            started_d = 1'b1;
          end else begin
            state_d = modexp_pkg::StSquare;
          end
        end else if (status_i.done) begin
          started_d = 1'b0;
          state_d = modexp_pkg::StSquare;
        end
      end
      modexp_pkg::StSquare: begin
        if (!started_q) begin
          if (status_i.last_bit) begin
            state_d = modexp_pkg::StDone;
          end else begin
            cmd_o.start = 1'b1;
            cmd_o.op = modexp_pkg::OpSquare;
            started_d = 1'b1;
          end
        end else if (status_i.done) begin
          started_d = 1'b0;
          cmd_o.exp_shift = 1'b1;
          state_d = modexp_pkg::StMulAcc;
        end
      end
      default: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) state_d = modexp_pkg::StIdle;
      end
    endcase
  end

  assign err_o = err_q;
  assign clr_o = clr_q;
endmodule

FILE: sv/modular_exponentiation.sv
// Top level of the modular exponentiation block.
// Computes base^exponent mod modulus, one request at a time: one reduction
// of the base, then per exponent bit an optional multiply and, except after
// the top bit, a square, each a start, OPERAND_WIDTH shift-and-add steps and
// a done in the bit-serial interleaved multiplier. A zero or unit modulus
// answers without any multiply; a zero modulus sets modulus_error. Write
// configuration only while idle.
module modular_exponentiation #(
  parameter int unsigned OPERAND_WIDTH = modexp_pkg::OperandWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] base_low_i,
  input  logic [63:0] base_high_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] power_low_o,
  output logic [63:0] power_high_o,
  output logic        modulus_error_o
);
  localparam int unsigned W = OPERAND_WIDTH;

  logic [63:0] mod_lo_q, mod_hi_q, exp_lo_q, exp_hi_q;
  logic [1:0] idx;
  logic wr;
  logic [127:0] mod_full, exp_full, base_full, acc_full;
  logic [W-1:0] acc;
  logic err, clr;
  modexp_pkg::dp_cmd_t cmd;
  modexp_pkg::dp_status_t status;

  assign pready = 1'b1;
  assign idx = paddr[4:3];
  assign wr = psel && penable && pwrite && (paddr[2:0] == 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_lo_q <= '0; mod_hi_q <= '0; exp_lo_q <= '0; exp_hi_q <= '0;
    end else if (wr) begin
      unique case (modexp_pkg::reg_idx_e'(idx))
        modexp_pkg::RegModLo: mod_lo_q <= pwdata;
        modexp_pkg::RegModHi: mod_hi_q <= pwdata;
        modexp_pkg::RegExpLo: exp_lo_q <= pwdata;
        default:              exp_hi_q <= pwdata;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      unique case (modexp_pkg::reg_idx_e'(idx))
        modexp_pkg::RegModLo: prdata = mod_lo_q;
        modexp_pkg::RegModHi: prdata = mod_hi_q;
        modexp_pkg::RegExpLo: prdata = exp_lo_q;
        default:              prdata = exp_hi_q;
      endcase
    end
  end

  assign mod_full = {mod_hi_q, mod_lo_q};
  assign exp_full = {exp_hi_q, exp_lo_q};
  assign base_full = {base_high_i, base_low_i};

  modexp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .err_o(err), .clr_o(clr), .cmd_o(cmd), .status_i(status)
  );

  modexp_datapath #(.OperandWidth(W)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd),
    .modulus_i(mod_full[W-1:0]),
    .exponent_i(exp_full[W-1:0]),
    .base_i(base_full[W-1:0]),
    .status_o(status),
    .acc_o(acc)
  );

  assign acc_full = 128'(acc);
  assign power_low_o = clr ? '0 : acc_full[63:0];
  assign power_high_o = clr ? '0 : acc_full[127:64];
  assign modulus_error_o = err;
endmodule
